@@ design/rehc_pkg.sv @@
// shared types and constants for the rssi ema hysteresis classifier
package rehc_pkg;

  localparam int NUM_LINKS = 8;
  localparam int LINK_W    = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
  localparam int WIN_LEN   = 3;
  localparam int LVL_W     = 8;
  localparam int ROW_W     = WIN_LEN * LVL_W;

  localparam logic signed [7:0]  LEVEL_START = -8'sd70;
  localparam logic signed [10:0] LEVEL_MAX   = 11'sd127;
  localparam logic signed [10:0] LEVEL_MIN   = -11'sd127;

  localparam logic signed [7:0] NEAR_RST   = -8'sd60;
  localparam logic signed [7:0] FAR_RST    = -8'sd75;
  localparam logic signed [7:0] LOST_RST   = -8'sd90;
  localparam logic [6:0]        MARGIN_RST = 7'd3;

  // reciprocal multipliers for truncating division of small magnitudes
  localparam logic [7:0] RECIP3     = 8'd171;
  localparam int         RECIP3_SH  = 9;
  localparam logic [7:0] RECIP10    = 8'd205;
  localparam int         RECIP10_SH = 11;

  typedef enum logic [1:0] {
    FUNC_SAMPLE,
    FUNC_ENABLE,
    FUNC_DISABLE,
    FUNC_RESET
  } func_t;

  typedef enum logic [1:0] {
    CLS_LOST,
    CLS_FAR,
    CLS_NEAR
  } lvl_cls_t;

  typedef enum logic [1:0] {
    REG_NEAR,
    REG_FAR,
    REG_LOST,
    REG_MARGIN
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMA,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic signed [7:0] near_level;
    logic signed [7:0] far_level;
    logic signed [7:0] lost_level;
    logic [6:0]        margin;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic ema;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

@@ design/rehc_ram.sv @@
// generic single write port ram with registered read
module rehc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/rehc_ctrl.sv @@
// controller sequencing capture, window load, ema step and commit
module rehc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output rehc_pkg::cmd_t cmd,
  input  rehc_pkg::sts_t sts
);
  import rehc_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD:   state_nxt = ST_EMA;
      ST_EMA:    state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_LOAD:   cmd.load   = 1'b1;
      ST_EMA:    cmd.ema    = 1'b1;
      ST_COMMIT: cmd.commit = sts.out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_commit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COMMIT && !sts.out_free |=> state_r == ST_COMMIT)
    else $error("commit left while output slot busy");

endmodule

@@ design/rehc_dp.sv @@
// datapath: per-link state, window averaging, ema, hysteresis and result register
module rehc_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rehc_pkg::cmd_t           cmd,
  output rehc_pkg::sts_t           sts,
  input  rehc_pkg::cfg_t           cfg,
  input  logic [1:0]               in_func,
  input  logic [2:0]               in_link_index,
  input  logic signed [7:0]        in_raw_level,
  input  logic                     out_tready,
  output logic                     out_tvalid,
  output logic [15:0]              out_tdata
);
  import rehc_pkg::*;

  func_t             func_r;
  logic [2:0]        idx_r;
  logic signed [7:0] raw_r;

  logic [1:0]        pos_r    [NUM_LINKS];
  logic [1:0]        fill_r   [NUM_LINKS];
  logic signed [7:0] level_r  [NUM_LINKS];
  logic              seeded_r [NUM_LINKS];
  lvl_cls_t          cls_r    [NUM_LINKS];
  logic              active_r [NUM_LINKS];

  logic [ROW_W-1:0]  row_r;
  logic [1:0]        pos_new_r;
  logic [1:0]        fill_new_r;
  logic signed [9:0] avg_r;
  logic signed [7:0] lvl_new_r;

  logic              out_tvalid_r;
  logic [15:0]       out_tdata_r;

  logic [LINK_W-1:0] k;
  logic              link_ok;
  logic [ROW_W-1:0]  ram_rdata;
  logic              ram_we;

  // load stage
  logic [1:0]        pos_cur;
  logic [1:0]        pos_nxt;
  logic [1:0]        fill_nxt;
  logic signed [7:0] ent [WIN_LEN];
  logic [ROW_W-1:0]  row_nxt;
  logic signed [9:0] sum_c;
  logic [9:0]        sum_abs;
  logic [17:0]       prod3;
  logic [8:0]        mag;
  logic signed [9:0] avg_nxt;

  // ema stage
  logic signed [7:0]  lvl_cur;
  logic signed [10:0] diff;
  logic signed [11:0] tri3;
  logic [9:0]         tri_abs;
  logic [17:0]        prod10;
  logic [6:0]         q;
  logic signed [10:0] step;
  logic signed [10:0] ema_sum;
  logic signed [7:0]  lvl_nxt;

  // commit stage
  logic signed [9:0] v10;
  logic signed [9:0] m10;
  logic signed [9:0] near10;
  logic signed [9:0] far10;
  logic signed [9:0] lost10;
  lvl_cls_t          cls_cur;
  lvl_cls_t          cls_smp;
  logic              do_sample;
  logic              do_clear;
  logic              res_acc;
  logic signed [7:0] res_lvl;
  lvl_cls_t          res_cls;
  logic              res_chg;
  logic [15:0]       out_tdata_nxt;

  assign k       = LINK_W'(idx_r);
  assign link_ok = int'(idx_r) < NUM_LINKS;

  rehc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_LINKS)
  ) u_win (
    .clk   (clk),
    .we    (ram_we),
    .waddr (k),
    .wdata (row_r),
    .re    (cmd.capture),
    .raddr (LINK_W'(in_link_index)),
    .rdata (ram_rdata)
  );

  always_comb begin
    pos_cur  = (pos_r[k] >= 2'(WIN_LEN)) ? 2'd0 : pos_r[k];
    pos_nxt  = (pos_cur == 2'(WIN_LEN - 1)) ? 2'd0 : pos_cur + 2'd1;
    fill_nxt = (fill_r[k] < 2'(WIN_LEN)) ? fill_r[k] + 2'd1 : 2'(WIN_LEN);
    for (int i = 0; i < WIN_LEN; i++) begin
      ent[i] = (2'(i) == pos_cur) ? raw_r : ram_rdata[i*LVL_W +: LVL_W];
      row_nxt[i*LVL_W +: LVL_W] = ent[i];
    end
    sum_c = 10'(ent[0])
          + ((fill_nxt > 2'd1) ? 10'(ent[1]) : 10'sd0)
          + ((fill_nxt > 2'd2) ? 10'(ent[2]) : 10'sd0);
    sum_abs = sum_c[9] ? 10'(-sum_c) : 10'(sum_c);
    prod3   = 18'(sum_abs) * 18'(RECIP3);
    unique case (fill_nxt)
      2'd1:    mag = 9'(sum_abs);
      2'd2:    mag = 9'(sum_abs >> 1);
      default: mag = 9'(prod3 >> RECIP3_SH);
    endcase
    avg_nxt = sum_c[9] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_comb begin
    lvl_cur = level_r[k];
    diff    = 11'(avg_r) - 11'(lvl_cur);
    tri3    = 12'(diff) + (12'(diff) <<< 1);
    tri_abs = tri3[11] ? 10'(-tri3) : 10'(tri3);
    prod10  = 18'(tri_abs) * 18'(RECIP10);
    q       = 7'(prod10 >> RECIP10_SH);
    step    = tri3[11] ? -$signed({4'b0, q}) : $signed({4'b0, q});
    ema_sum = seeded_r[k] ? 11'(lvl_cur) + step : 11'(avg_r);
    if (ema_sum > LEVEL_MAX) begin
      lvl_nxt = 8'(LEVEL_MAX);
    end else if (ema_sum < LEVEL_MIN) begin
      lvl_nxt = 8'(LEVEL_MIN);
    end else begin
      lvl_nxt = 8'(ema_sum);
    end
  end

  always_comb begin
    v10     = 10'(lvl_new_r);
    m10     = $signed({3'b0, cfg.margin});
    near10  = 10'(cfg.near_level);
    far10   = 10'(cfg.far_level);
    lost10  = 10'(cfg.lost_level);
    cls_cur = cls_r[k];
    unique case (cls_cur)
      CLS_LOST: cls_smp = (v10 > far10 + m10) ? CLS_FAR : CLS_LOST;
      CLS_FAR: begin
        if (v10 < lost10 - m10) begin
          cls_smp = CLS_LOST;
        end else if (v10 > near10 + m10) begin
          cls_smp = CLS_NEAR;
        end else begin
          cls_smp = CLS_FAR;
        end
      end
      CLS_NEAR: cls_smp = (v10 < far10 - m10) ? CLS_FAR : CLS_NEAR;
      default:  cls_smp = CLS_LOST;
    endcase

    do_sample = link_ok && func_r == FUNC_SAMPLE && active_r[k];
    do_clear  = link_ok && (func_r == FUNC_ENABLE || func_r == FUNC_RESET);
    res_acc   = link_ok && (func_r != FUNC_SAMPLE || active_r[k]);
    res_chg   = do_sample && cls_smp != cls_cur;
    if (!link_ok) begin
      res_lvl = '0;
      res_cls = CLS_LOST;
    end else if (do_sample) begin
      res_lvl = lvl_new_r;
      res_cls = cls_smp;
    end else if (do_clear) begin
      res_lvl = LEVEL_START;
      res_cls = CLS_LOST;
    end else begin
      res_lvl = level_r[k];
      res_cls = cls_cur;
    end
    ram_we        = cmd.commit && do_sample;
    out_tdata_nxt = {1'b0, res_chg, res_cls, res_lvl, res_acc, idx_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func_t'(in_func);
      idx_r  <= in_link_index;
      raw_r  <= in_raw_level;
    end
    if (cmd.load) begin
      row_r      <= row_nxt;
      pos_new_r  <= pos_nxt;
      fill_new_r <= fill_nxt;
      avg_r      <= avg_nxt;
    end
    if (cmd.ema) begin
      lvl_new_r <= lvl_nxt;
    end
    if (cmd.commit) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LINKS; i++) begin
        pos_r[i]    <= 2'd0;
        fill_r[i]   <= 2'd0;
        level_r[i]  <= LEVEL_START;
        seeded_r[i] <= 1'b0;
        cls_r[i]    <= CLS_LOST;
        active_r[i] <= 1'b0;
      end
    end else if (cmd.commit && link_ok) begin
      if (do_sample) begin
        pos_r[k]    <= pos_new_r;
        fill_r[k]   <= fill_new_r;
        level_r[k]  <= lvl_new_r;
        seeded_r[k] <= 1'b1;
        cls_r[k]    <= cls_smp;
      end else if (do_clear) begin
        pos_r[k]    <= 2'd0;
        fill_r[k]   <= 2'd0;
        level_r[k]  <= LEVEL_START;
        seeded_r[k] <= 1'b0;
        cls_r[k]    <= CLS_LOST;
      end
      if (func_r == FUNC_ENABLE) begin
        active_r[k] <= 1'b1;
      end else if (func_r == FUNC_DISABLE) begin
        active_r[k] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  assign sts.out_free = !out_tvalid_r || out_tready;
  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;

  a_chg_needs_acc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> !(out_tdata_r[14] && !out_tdata_r[3]))
    else $error("class change reported on an ignored request");

  a_level_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> out_tdata_r[11:4] != 8'h80)
    else $error("filtered level outside clamp range");

  a_seeded_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && do_sample |=> seeded_r[k])
    else $error("link not seeded after a sample");

endmodule

@@ design/rssi_ema_hysteresis_classifier.sv @@
// top level: config registers, controller and datapath of the level classifier
//
// Requests arrive on the in_ stream: in_tuser carries the function (sample,
// enable link, disable link, reset filter), in_tdata the link index and the
// raw signed level. Every request yields exactly one result on the out_
// stream with the link index, an accepted flag, the filtered level, the
// distance class and a class-changed flag.
// A request is taken only when the block is idle; it then passes through
// capture with window row read, window average, ema step, then class update
// and write-back, and the result is registered at that last step. No new
// request is taken until the last one has committed, since the controller
// serializes the per-link read-modify-write.
// A result waits in the output register while out_tready is low; the next
// request is still taken and is held at its commit step until that slot
// frees.
// Reset sets the thresholds to their defaults and marks every link inactive,
// lost, unseeded at level -70. Thresholds are to be written through the cfg_
// port only while no request is in flight; the block itself does not enforce it.
module rssi_ema_hysteresis_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // link_index[2:0], raw_level[10:3], zero pad
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_link_index[2:0], accepted[3],
                                  // filtered_level[11:4], distance_class[13:12],
                                  // class_changed[14], zero pad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rehc_pkg::*;

  logic signed [7:0] near_r;
  logic signed [7:0] far_r;
  logic signed [7:0] lost_r;
  logic [6:0]        margin_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  cfg_t              cfg;
  cmd_t              cmd;
  sts_t              sts;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r   <= NEAR_RST;
      far_r    <= FAR_RST;
      lost_r   <= LOST_RST;
      margin_r <= MARGIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NEAR:   near_r   <= cfg_pwdata[7:0];
        REG_FAR:    far_r    <= cfg_pwdata[7:0];
        REG_LOST:   lost_r   <= cfg_pwdata[7:0];
        REG_MARGIN: margin_r <= cfg_pwdata[6:0];
        default:    margin_r <= margin_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NEAR:   cfg_prdata = {24'b0, near_r};
      REG_FAR:    cfg_prdata = {24'b0, far_r};
      REG_LOST:   cfg_prdata = {24'b0, lost_r};
      REG_MARGIN: cfg_prdata = {25'b0, margin_r};
      default:    cfg_prdata = '0;
    endcase
  end

  assign cfg.near_level = near_r;
  assign cfg.far_level  = far_r;
  assign cfg.lost_level = lost_r;
  assign cfg.margin     = margin_r;

  rehc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rehc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg           (cfg),
    .in_func       (in_tuser),
    .in_link_index (in_tdata[2:0]),
    .in_raw_level  (in_tdata[10:3]),
    .out_tready    (out_tready),
    .out_tvalid    (out_tvalid),
    .out_tdata     (out_tdata)
  );

endmodule
